// ----- sv/rpv_pkg.sv -----
// shared types, constants and helpers for the vertex rotate and project pipeline
`timescale 1ns / 1ps
package rpv_pkg;

    localparam int TRIG_FRAC_BITS  = 14;
    localparam int SCALE_FRAC_BITS = 4;
    localparam int Q_BITS          = 18;

    typedef enum logic [3:0] {
        REG_SIN_X    = 4'd0,
        REG_COS_X    = 4'd1,
        REG_SIN_Y    = 4'd2,
        REG_COS_Y    = 4'd3,
        REG_CAM_DIST = 4'd4,
        REG_PROJ     = 4'd5,
        REG_CENTER_X = 4'd6,
        REG_CENTER_Y = 4'd7
    } t_reg_index;

    typedef struct packed {
        logic signed [15:0] sin_x;
        logic signed [15:0] cos_x;
        logic signed [15:0] sin_y;
        logic signed [15:0] cos_y;
        logic        [14:0] cam_dist;
    } t_rot_cfg;

    typedef struct packed {
        logic               valid;
        logic signed [16:0] view_x;
        logic signed [16:0] view_y;
        logic signed [16:0] view_z;
        logic               behind;
        logic               neg_x;
        logic               neg_y;
        logic               ovf_x;
        logic               ovf_y;
    } t_side;

    function automatic logic signed [16:0] sat_view(input logic signed [22:0] v);
        if (v > 23'sd65535) begin
            return 17'sd65535;
        end else if (v < -23'sd65536) begin
            return -17'sd65536;
        end
        return v[16:0];
    endfunction

    function automatic logic signed [15:0] sat_screen(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'sd32767;
        end else if (v < -20'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

endpackage

// ----- sv/rpv_rotate.sv -----
// four-stage rotation about y then x, camera offset and view saturation
`timescale 1ns / 1ps
module rpv_rotate
    import rpv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_rot_cfg            i_cfg,
    input  logic                i_valid,
    input  logic signed [15:0]  i_x,
    input  logic signed [15:0]  i_y,
    input  logic signed [15:0]  i_z,
    output logic                o_valid,
    output logic signed [16:0]  o_view_x,
    output logic signed [16:0]  o_view_y,
    output logic signed [16:0]  o_view_z,
    output logic                o_behind
);
    logic [3:0] r_valid;

    logic signed [31:0] r_xc, r_zs, r_zc, r_xs;
    logic signed [15:0] r_y1;
    logic signed [18:0] r_x1, r_z1;
    logic signed [15:0] r_y2;
    logic signed [18:0] r_x3;
    logic signed [34:0] r_yc, r_zsx, r_ys, r_zcx;
    logic signed [16:0] r_vx, r_vy, r_vz;
    logic               r_behind;

    logic signed [32:0] n_sx, n_sz;
    logic signed [18:0] n_x1, n_z1;
    logic signed [35:0] n_sy, n_sz2;
    logic signed [21:0] n_y2, n_z2;
    logic signed [22:0] n_vz;

    always_comb begin
        n_sx  = 33'(r_xc) + 33'(r_zs) + 33'sd8192;
        n_sz  = 33'(r_zc) - 33'(r_xs) + 33'sd8192;
        n_x1  = 19'(n_sx >>> TRIG_FRAC_BITS);
        n_z1  = 19'(n_sz >>> TRIG_FRAC_BITS);
        n_sy  = 36'(r_yc) - 36'(r_zsx) + 36'sd8192;
        n_sz2 = 36'(r_ys) + 36'(r_zcx) + 36'sd8192;
        n_y2  = 22'(n_sy >>> TRIG_FRAC_BITS);
        n_z2  = 22'(n_sz2 >>> TRIG_FRAC_BITS);
        n_vz  = 23'(n_z2) + 23'($signed({1'b0, i_cfg.cam_dist}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xc   <= i_x * i_cfg.cos_y;
            r_zs   <= i_z * i_cfg.sin_y;
            r_zc   <= i_z * i_cfg.cos_y;
            r_xs   <= i_x * i_cfg.sin_y;
            r_y1   <= i_y;
            r_x1   <= n_x1;
            r_z1   <= n_z1;
            r_y2   <= r_y1;
            r_x3   <= r_x1;
            r_yc   <= 35'(r_y2 * i_cfg.cos_x);
            r_zsx  <= r_z1 * i_cfg.sin_x;
            r_ys   <= 35'(r_y2 * i_cfg.sin_x);
            r_zcx  <= r_z1 * i_cfg.cos_x;
            r_vx   <= sat_view(23'(r_x3));
            r_vy   <= sat_view(23'(n_y2));
            r_vz   <= sat_view(n_vz);
            r_behind <= (sat_view(n_vz) <= 17'sd0);
        end
    end

    assign o_valid  = r_valid[3];
    assign o_view_x = r_vx;
    assign o_view_y = r_vy;
    assign o_view_z = r_vz;
    assign o_behind = r_behind;
endmodule

// ----- sv/rpv_div_lane.sv -----
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module rpv_div_lane
    import rpv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [32:0]       i_num,
    input  logic [20:0]       i_den,
    output logic [Q_BITS-1:0] o_quo
);
    logic [32:0]       r_rem [Q_BITS];
    logic [20:0]       r_den [Q_BITS];
    logic [Q_BITS-1:0] r_quo [Q_BITS];

    for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
        localparam int K = Q_BITS - 1 - j;
        logic [32:0]       n_rem_in;
        logic [20:0]       n_den_in;
        logic [Q_BITS-1:0] n_quo_in;
        logic [39:0]       n_trial;
        logic              n_take;

        if (j == 0) begin : g_first
            assign n_rem_in = i_num;
            assign n_den_in = i_den;
            assign n_quo_in = '0;
        end else begin : g_next
            assign n_rem_in = r_rem[j-1];
            assign n_den_in = r_den[j-1];
            assign n_quo_in = r_quo[j-1];
        end

        assign n_trial = 40'(n_den_in) << K;
        assign n_take  = (40'(n_rem_in) >= n_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_take ? 33'(40'(n_rem_in) - n_trial) : n_rem_in;
                r_den[j] <= n_den_in;
                r_quo[j] <= n_quo_in | (Q_BITS'(n_take) << K);
            end
        end
    end

    assign o_quo = r_quo[Q_BITS-1];
endmodule

// ----- sv/rotate_project_vertex.sv -----
// top level: config registers, rotation, projection divide and output stage
`timescale 1ns / 1ps
// Rotates one Q4.12 vertex about Y then X, adds the camera distance and
// projects it to screen pixels. One vertex is taken every clock while
// o_stall is low, and passes through 25 register stages (4 rotation
// stages, 2 projection setup stages, 18 divider stages of one
// quotient bit each, 1 output stage). The whole pipeline holds while a
// result waits under i_stall. Registers are to be written only with the
// pipeline empty (not enforced by the block); o_cfg_ready is always high.
module rotate_project_vertex
    import rpv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_model_x,
    input  logic signed [15:0] i_model_y,
    input  logic signed [15:0] i_model_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [16:0] o_view_x,
    output logic signed [16:0] o_view_y,
    output logic signed [16:0] o_view_z,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic               o_behind_camera
);
    t_rot_cfg    r_cfg;
    logic [15:0] r_proj;
    logic [11:0] r_cx, r_cy;
    logic        en;

    assign o_cfg_ready = 1'b1;
    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sin_x    <= 16'sd6380;
            r_cfg.cos_x    <= 16'sd15090;
            r_cfg.sin_y    <= 16'sd0;
            r_cfg.cos_y    <= 16'sd16384;
            r_cfg.cam_dist <= 15'd17203;
            r_proj         <= 16'd2568;
            r_cx           <= 12'd360;
            r_cy           <= 12'd280;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SIN_X:    r_cfg.sin_x    <= i_cfg_data;
                REG_COS_X:    r_cfg.cos_x    <= i_cfg_data;
                REG_SIN_Y:    r_cfg.sin_y    <= i_cfg_data;
                REG_COS_Y:    r_cfg.cos_y    <= i_cfg_data;
                REG_CAM_DIST: r_cfg.cam_dist <= i_cfg_data[14:0];
                REG_PROJ:     r_proj         <= i_cfg_data;
                REG_CENTER_X: r_cx           <= i_cfg_data[11:0];
                REG_CENTER_Y: r_cy           <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // rotation
    logic               rot_valid, rot_behind;
    logic signed [16:0] rot_vx, rot_vy, rot_vz;

    rpv_rotate u_rotate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .i_x      (i_model_x),
        .i_y      (i_model_y),
        .i_z      (i_model_z),
        .o_valid  (rot_valid),
        .o_view_x (rot_vx),
        .o_view_y (rot_vy),
        .o_view_z (rot_vz),
        .o_behind (rot_behind)
    );

    // projection setup: numerators, then magnitudes and range check
    logic               r_a_valid, r_b_valid;
    logic signed [33:0] r_a_nx, r_a_ny;
    logic [20:0]        r_a_den, r_b_den;
    logic signed [16:0] r_a_vx, r_a_vy, r_a_vz;
    logic               r_a_behind;
    logic [32:0]        r_b_mx, r_b_my;
    t_side              r_b_side;
    logic [32:0]        n_mx, n_my;
    logic [38:0]        n_lim;

    always_comb begin
        n_mx  = r_a_nx[33] ? 33'(-r_a_nx) : 33'(r_a_nx);
        n_my  = r_a_ny[33] ? 33'(-r_a_ny) : 33'(r_a_ny);
        n_lim = 39'(r_a_den) << Q_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= rot_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_nx     <= $signed({1'b0, r_proj}) * rot_vx;
            r_a_ny     <= $signed({1'b0, r_proj}) * rot_vy;
            r_a_den    <= {rot_vz[16:0], 4'b0000};
            r_a_vx     <= rot_vx;
            r_a_vy     <= rot_vy;
            r_a_vz     <= rot_vz;
            r_a_behind <= rot_behind;
            r_b_mx     <= n_mx;
            r_b_my     <= n_my;
            r_b_den    <= r_a_den;
            r_b_side.valid  <= 1'b0;
            r_b_side.view_x <= r_a_vx;
            r_b_side.view_y <= r_a_vy;
            r_b_side.view_z <= r_a_vz;
            r_b_side.behind <= r_a_behind;
            r_b_side.neg_x  <= r_a_nx[33];
            r_b_side.neg_y  <= r_a_ny[33];
            r_b_side.ovf_x  <= (39'(n_mx) >= n_lim);
            r_b_side.ovf_y  <= (39'(n_my) >= n_lim);
        end
    end

    // divider lanes and matching side line
    logic [Q_BITS-1:0] quo_x, quo_y;

    rpv_div_lane u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_b_mx),
        .i_den (r_b_den),
        .o_quo (quo_x)
    );

    rpv_div_lane u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_b_my),
        .i_den (r_b_den),
        .o_quo (quo_y)
    );

    t_side r_side [Q_BITS];

    for (genvar j = 0; j < Q_BITS; j++) begin : g_side
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side[j].valid <= 1'b0;
                end else if (en) begin
                    r_side[j].valid <= r_b_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_side[j].view_x <= r_b_side.view_x;
                    r_side[j].view_y <= r_b_side.view_y;
                    r_side[j].view_z <= r_b_side.view_z;
                    r_side[j].behind <= r_b_side.behind;
                    r_side[j].neg_x  <= r_b_side.neg_x;
                    r_side[j].neg_y  <= r_b_side.neg_y;
                    r_side[j].ovf_x  <= r_b_side.ovf_x;
                    r_side[j].ovf_y  <= r_b_side.ovf_y;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side[j].valid <= 1'b0;
                end else if (en) begin
                    r_side[j].valid <= r_side[j-1].valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_side[j].view_x <= r_side[j-1].view_x;
                    r_side[j].view_y <= r_side[j-1].view_y;
                    r_side[j].view_z <= r_side[j-1].view_z;
                    r_side[j].behind <= r_side[j-1].behind;
                    r_side[j].neg_x  <= r_side[j-1].neg_x;
                    r_side[j].neg_y  <= r_side[j-1].neg_y;
                    r_side[j].ovf_x  <= r_side[j-1].ovf_x;
                    r_side[j].ovf_y  <= r_side[j-1].ovf_y;
                end
            end
        end
    end

    // output stage
    t_side              last;
    logic [Q_BITS-1:0]  n_qmx, n_qmy;
    logic signed [19:0] n_qx, n_qy, n_sx, n_sy;
    logic               r_valid;
    logic signed [16:0] r_vx, r_vy, r_vz;
    logic signed [15:0] r_sx, r_sy;
    logic               r_behind;

    always_comb begin
        last  = r_side[Q_BITS-1];
        n_qmx = last.ovf_x ? '1 : quo_x;
        n_qmy = last.ovf_y ? '1 : quo_y;
        n_qx  = last.neg_x ? -20'(n_qmx) : 20'(n_qmx);
        n_qy  = last.neg_y ? -20'(n_qmy) : 20'(n_qmy);
        n_sx  = 20'(r_cx) + n_qx;
        n_sy  = 20'(r_cy) - n_qy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vx     <= last.view_x;
            r_vy     <= last.view_y;
            r_vz     <= last.view_z;
            r_behind <= last.behind;
            r_sx     <= last.behind ? 16'(r_cx) : sat_screen(n_sx);
            r_sy     <= last.behind ? 16'(r_cy) : sat_screen(n_sy);
        end
    end

    assign o_valid         = r_valid;
    assign o_view_x        = r_vx;
    assign o_view_y        = r_vy;
    assign o_view_z        = r_vz;
    assign o_screen_x      = r_sx;
    assign o_screen_y      = r_sy;
    assign o_behind_camera = r_behind;

`ifndef SYNTHESIS
    a_behind_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_behind_camera |-> o_screen_x == 16'(r_cx) && o_screen_y == 16'(r_cy))
        else $error("behind-camera result not at view center");
    a_front_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_behind_camera |-> o_view_z > 17'sd0)
        else $error("projected result with non-positive view z");
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");
`endif
endmodule
